[rtl/i2c_master_transfer_sequencer_unit_assert.svh]
// Assertion macros for the I2C master transfer sequencer.
// Expects clk and rst_n in the scope of each use.
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_UNIT_ASSERT_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define MTS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2c sequencer check failed");

// Next-cycle implication.
`define MTS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2c sequencer check failed");

`endif

[rtl/i2c_mts_pkg.sv]
// Shared types and codes of the I2C master transfer sequencer.
// No dependencies.
`default_nettype none

package i2c_mts_pkg;

  typedef enum logic [2:0] {
    CMD_LOAD_BYTE   = 3'd0,
    CMD_START_WRITE = 3'd1,
    CMD_START_READ  = 3'd2,
    CMD_BUS_STATUS  = 3'd3,
    CMD_READ_ENTRY  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_START     = 3'd1,
    ACT_SEND      = 3'd2,
    ACT_RECV_ACK  = 3'd3,
    ACT_RECV_NACK = 3'd4,
    ACT_STOP      = 3'd5,
    ACT_RESTART   = 3'd6,
    ACT_RELEASE   = 3'd7
  } act_t;

  localparam logic [7:0] ST_START       = 8'h08;
  localparam logic [7:0] ST_RSTART      = 8'h10;
  localparam logic [7:0] ST_ADDR_ACK_W  = 8'h18;
  localparam logic [7:0] ST_DATA_ACK_W  = 8'h28;
  localparam logic [7:0] ST_ARB_LOST    = 8'h38;
  localparam logic [7:0] ST_ADDR_ACK_R  = 8'h40;
  localparam logic [7:0] ST_DATA_ACK_R  = 8'h50;
  localparam logic [7:0] ST_DATA_NACK_R = 8'h58;
  localparam logic [7:0] NO_FAULT       = 8'hF8;

  typedef struct packed {
    logic       accepted;
    act_t       action;
    logic       busy;
    logic       ok;
    logic [7:0] fault;
    logic       tx_sel;
    logic       rd_sel;
  } meta_t;

  typedef struct packed {
    logic       accepted;
    act_t       action;
    logic [7:0] tx_byte;
    logic       busy_res;
    logic       transfer_ok;
    logic [7:0] fault_status;
    logic [7:0] read_byte;
  } rslt_t;

  typedef struct packed {
    logic s1_valid;
    logic s2_valid;
  } pipe_stat_t;

endpackage

`default_nettype wire

[rtl/i2c_mts_if.sv]
// Request and result channel interfaces of the I2C master transfer sequencer.
// No dependencies.
`default_nettype none

interface i2c_mts_in_if ();
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [6:0] slave_address;
  logic [3:0] transfer_length;
  logic [3:0] buffer_index;
  logic [7:0] load_byte_value;
  logic [7:0] status_code;
  logic [7:0] received_byte;

  modport source (
    output valid, command, slave_address, transfer_length, buffer_index,
           load_byte_value, status_code, received_byte,
    input  ready
  );
  modport sink (
    input  valid, command, slave_address, transfer_length, buffer_index,
           load_byte_value, status_code, received_byte,
    output ready
  );
endinterface

interface i2c_mts_out_if ();
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [2:0] bus_action;
  logic [7:0] tx_byte;
  logic       busy_res;
  logic       transfer_ok;
  logic [7:0] fault_status;
  logic [7:0] read_byte;

  modport source (
    output valid, accepted, bus_action, tx_byte, busy_res, transfer_ok,
           fault_status, read_byte,
    input  ready
  );
  modport sink (
    input  valid, accepted, bus_action, tx_byte, busy_res, transfer_ok,
           fault_status, read_byte,
    output ready
  );
endinterface

`default_nettype wire

[rtl/i2c_mts_mem.sv]
// Byte buffer of the I2C master transfer sequencer: one write, one registered read.
// No dependencies.
`default_nettype none

module i2c_mts_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[rtl/i2c_mts_ctrl.sv]
// Transfer control of the I2C master transfer sequencer: pointer, length, flags
// and fault status, plus the buffer access of each request. Uses i2c_mts_pkg.
`default_nettype none

module i2c_mts_ctrl import i2c_mts_pkg::*; #(
  parameter int BUFFER_DEPTH = 16,
  parameter int AW           = 4,
  parameter int PW           = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  logic [2:0]    command,
  input  logic [6:0]    slave_address,
  input  logic [3:0]    transfer_length,
  input  logic [3:0]    buffer_index,
  input  logic [7:0]    load_byte_value,
  input  logic [7:0]    status_code,
  input  logic [7:0]    received_byte,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [7:0]    mem_wdata,
  output logic          mem_re,
  output logic [AW-1:0] mem_raddr,
  output meta_t         meta
);

  localparam int CW = (PW > 5) ? PW : 5;

  logic [PW-1:0] ptr_r, ptr_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          ok_r, ok_nxt;
  logic [7:0]    fault_r, fault_nxt;

  logic [4:0]    idx_p1;
  logic [PW-1:0] eff_ptr;
  logic [PW-1:0] ptr_inc;
  logic          acc;
  act_t          act;
  logic          tx_sel;
  logic          rd_sel;

  assign idx_p1 = {1'b0, buffer_index} + 5'd1;

  always_comb begin
    ptr_nxt   = ptr_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    ok_nxt    = ok_r;
    fault_nxt = fault_r;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    acc       = 1'b0;
    act       = ACT_NONE;
    tx_sel    = 1'b0;
    rd_sel    = 1'b0;
    eff_ptr   = ptr_r;
    ptr_inc   = ptr_r;
    case (cmd_t'(command))
      CMD_LOAD_BYTE: begin
        if (!busy_r && CW'(idx_p1) < CW'(BUFFER_DEPTH)) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(idx_p1);
          mem_wdata = load_byte_value;
          acc       = 1'b1;
        end
      end
      CMD_START_WRITE, CMD_START_READ: begin
        if (!busy_r) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = {slave_address, (cmd_t'(command) == CMD_START_READ)};
          cnt_nxt   = transfer_length;
          ptr_nxt   = '0;
          busy_nxt  = 1'b1;
          ok_nxt    = 1'b0;
          act       = ACT_START;
          acc       = 1'b1;
        end
      end
      CMD_BUS_STATUS: begin
        if (busy_r) begin
          acc = 1'b1;
          case (status_code)
            ST_START, ST_RSTART, ST_ADDR_ACK_W, ST_DATA_ACK_W: begin
              if (status_code inside {ST_START, ST_RSTART}) begin
                eff_ptr = '0;
              end
              if (CW'(eff_ptr) <= CW'(cnt_r) && eff_ptr < PW'(BUFFER_DEPTH)) begin
                mem_re    = 1'b1;
                mem_raddr = AW'(eff_ptr);
                ptr_nxt   = eff_ptr + PW'(1);
                act       = ACT_SEND;
                tx_sel    = 1'b1;
              end else begin
                ptr_nxt  = eff_ptr;
                ok_nxt   = 1'b1;
                busy_nxt = 1'b0;
                act      = ACT_STOP;
              end
            end
            ST_ADDR_ACK_R: begin
              if (cnt_r == 4'd0) begin
                ok_nxt   = 1'b1;
                busy_nxt = 1'b0;
                act      = ACT_STOP;
              end else if (cnt_r == 4'd1) begin
                act = ACT_RECV_NACK;
              end else begin
                act = ACT_RECV_ACK;
              end
            end
            ST_DATA_ACK_R: begin
              if (ptr_r < PW'(BUFFER_DEPTH)) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(ptr_r);
                mem_wdata = received_byte;
                ptr_inc   = ptr_r + PW'(1);
              end
              ptr_nxt = ptr_inc;
              act     = (CW'(ptr_inc) >= CW'(cnt_r)) ? ACT_RECV_NACK : ACT_RECV_ACK;
            end
            ST_DATA_NACK_R: begin
              if (ptr_r < PW'(BUFFER_DEPTH)) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(ptr_r);
                mem_wdata = received_byte;
              end
              ok_nxt   = 1'b1;
              busy_nxt = 1'b0;
              act      = ACT_STOP;
            end
            ST_ARB_LOST: begin
              act = ACT_RESTART;
            end
            default: begin
              fault_nxt = status_code;
              busy_nxt  = 1'b0;
              act       = ACT_RELEASE;
            end
          endcase
        end
      end
      CMD_READ_ENTRY: begin
        acc = 1'b1;
        if (CW'(buffer_index) < CW'(BUFFER_DEPTH)) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(buffer_index);
          rd_sel    = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (!fire) begin
      mem_we = 1'b0;
      mem_re = 1'b0;
    end
  end

  always_comb begin
    meta.accepted = acc;
    meta.action   = act;
    meta.busy     = busy_nxt;
    meta.ok       = ok_nxt;
    meta.fault    = fault_nxt;
    meta.tx_sel   = tx_sel;
    meta.rd_sel   = rd_sel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r   <= '0;
      cnt_r   <= '0;
      busy_r  <= 1'b0;
      ok_r    <= 1'b0;
      fault_r <= NO_FAULT;
    end else if (fire) begin
      ptr_r   <= ptr_nxt;
      cnt_r   <= cnt_nxt;
      busy_r  <= busy_nxt;
      ok_r    <= ok_nxt;
      fault_r <= fault_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/i2c_mts_out.sv]
// Result pipeline of the I2C master transfer sequencer: buffer read stage and
// output register with flow control. Uses i2c_mts_pkg.
`default_nettype none

module i2c_mts_out import i2c_mts_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  meta_t      meta_in,
  input  logic [7:0] rdata,
  input  logic       out_ready,
  output logic       out_valid,
  output rslt_t      rslt,
  output logic       in_ready,
  output pipe_stat_t stat
);

  logic  s1_valid_r, s1_valid_nxt;
  meta_t s1_meta_r;
  logic  s2_valid_r, s2_valid_nxt;
  rslt_t s2_rslt_r;
  rslt_t s2_rslt_nxt;
  logic  s1_adv;

  assign s1_adv   = s1_valid_r && (!s2_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    s2_valid_nxt = s2_valid_r;
    if (s1_adv) begin
      s2_valid_nxt = 1'b1;
    end else if (out_ready) begin
      s2_valid_nxt = 1'b0;
    end
    s2_rslt_nxt.accepted     = s1_meta_r.accepted;
    s2_rslt_nxt.action       = s1_meta_r.action;
    s2_rslt_nxt.tx_byte      = s1_meta_r.tx_sel ? rdata : 8'd0;
    s2_rslt_nxt.busy_res     = s1_meta_r.busy;
    s2_rslt_nxt.transfer_ok  = s1_meta_r.ok;
    s2_rslt_nxt.fault_status = s1_meta_r.fault;
    s2_rslt_nxt.read_byte    = s1_meta_r.rd_sel ? rdata : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_meta_r <= meta_in;
    end
    if (s1_adv) begin
      s2_rslt_r <= s2_rslt_nxt;
    end
  end

  assign out_valid     = s2_valid_r;
  assign rslt          = s2_rslt_r;
  assign stat.s1_valid = s1_valid_r;
  assign stat.s2_valid = s2_valid_r;

endmodule

`default_nettype wire

[rtl/i2c_master_transfer_sequencer_unit.sv]
// Top level of the I2C master transfer sequencer: control, byte buffer, result pipeline.
// Uses i2c_mts_pkg, i2c_mts_if, i2c_mts_ctrl, i2c_mts_mem, i2c_mts_out.
//
//   channel   dir  handshake          payload
//   in_ch     in   valid/ready        command, address, length, index, bytes, status
//   out_ch    out  valid/ready        accepted, bus action, tx/read bytes, flags, fault
//
// One request per cycle while the result channel is not stalled; a result passes
// through the registered read port of the byte buffer and then the output register.
// Control state updates at acceptance, so consecutive requests need no interlock.
// Reset clears pointer, length and flags and sets the fault status to 0xF8.
// A stalled result holds in the output register while one more request is taken.
`default_nettype none
`include "i2c_master_transfer_sequencer_unit_assert.svh"

module i2c_master_transfer_sequencer_unit import i2c_mts_pkg::*; #(
  parameter int BUFFER_DEPTH = 16
) (
  input logic           clk,
  input logic           rst_n,
  i2c_mts_in_if.sink    in_ch,
  i2c_mts_out_if.source out_ch
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int PW = $clog2(BUFFER_DEPTH + 1);

  logic          in_fire;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  meta_t         meta;
  rslt_t         rslt;
  logic          in_ready;
  pipe_stat_t    stat;

  assign in_fire     = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  i2c_mts_ctrl #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .AW           (AW),
    .PW           (PW)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .fire            (in_fire),
    .command         (in_ch.command),
    .slave_address   (in_ch.slave_address),
    .transfer_length (in_ch.transfer_length),
    .buffer_index    (in_ch.buffer_index),
    .load_byte_value (in_ch.load_byte_value),
    .status_code     (in_ch.status_code),
    .received_byte   (in_ch.received_byte),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_re          (mem_re),
    .mem_raddr       (mem_raddr),
    .meta            (meta)
  );

  i2c_mts_mem #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  i2c_mts_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .meta_in   (meta),
    .rdata     (mem_rdata),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .rslt      (rslt),
    .in_ready  (in_ready),
    .stat      (stat)
  );

  assign out_ch.accepted     = rslt.accepted;
  assign out_ch.bus_action   = rslt.action;
  assign out_ch.tx_byte      = rslt.tx_byte;
  assign out_ch.busy_res     = rslt.busy_res;
  assign out_ch.transfer_ok  = rslt.transfer_ok;
  assign out_ch.fault_status = rslt.fault_status;
  assign out_ch.read_byte    = rslt.read_byte;

  `MTS_ASSERT_IMP(a_send_busy, out_ch.valid && out_ch.bus_action == ACT_SEND,
                  out_ch.accepted && out_ch.busy_res)
  `MTS_ASSERT_IMP(a_stop_done, out_ch.valid && out_ch.bus_action == ACT_STOP,
                  out_ch.transfer_ok && !out_ch.busy_res)
  `MTS_ASSERT_IMP(a_no_overrun, in_ch.ready,
                  !stat.s1_valid || !stat.s2_valid || out_ch.ready)
  `MTS_ASSERT_NXT(a_fire_fills, in_fire, stat.s1_valid)

endmodule

`default_nettype wire
